### hw/rtl/euler_to_quaternion_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Euler to quaternion block
// Concurrent check wrappers; NO_ASSERTIONS compiles them out.
// ---------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define ETQ_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ETQ_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define ETQ_ASSERT_IMPLY(label, clk, rst, a, b, msg)
`define ETQ_ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif
`endif

### hw/rtl/etq_pkg.sv
// ---------------------------------------------------------------------------
// etq_pkg
// Shared types, constants and the arctangent table of the Euler to
// quaternion datapath.
// ---------------------------------------------------------------------------
package etq_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int QUAT_WIDTH_DEF  = 16;
  localparam int TRIG_ITER_DEF   = 16;

  // internal trig word: Q30 with headroom for the doubled input range
  localparam int TW = 34;
  // multiplier operand width
  localparam int MW = 32;

  typedef logic signed [TW-1:0] trig_word_t;
  typedef logic signed [MW-1:0] mul_word_t;

  localparam trig_word_t PI_Q30      = 34'sd3373259426;
  localparam trig_word_t HALF_PI_Q30 = 34'sd1686629713;
  localparam trig_word_t INV_GAIN    = 34'sd652032874;

  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // one CORDIC lane: cosine, sine, residual angle, quadrant flip
  typedef struct packed {
    trig_word_t x;
    trig_word_t y;
    trig_word_t z;
    logic       flip;
  } trig_lane_t;

  typedef struct packed {
    trig_lane_t yaw;
    trig_lane_t pitch;
    trig_lane_t roll;
  } trig_set_t;

  // the eight triple products, a and b terms of each component
  typedef struct packed {
    trig_word_t x_a;
    trig_word_t x_b;
    trig_word_t y_a;
    trig_word_t y_b;
    trig_word_t z_a;
    trig_word_t z_b;
    trig_word_t w_a;
    trig_word_t w_b;
  } prod_set_t;

  function automatic trig_word_t atan_q30(input logic [4:0] idx);
    return signed'({2'b00, ATAN_TABLE[idx]});
  endfunction

  // (a*b + 2^29) >> 30, floor shift
  function automatic trig_word_t mul_q30(input mul_word_t a, input mul_word_t b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    return TW'(p >>> 30);
  endfunction

endpackage

### hw/rtl/etq_if.sv
// ---------------------------------------------------------------------------
// etq_angle_if / etq_quat_if
// Valid/ready channels for the angle words and the quaternion words.
// ---------------------------------------------------------------------------
interface etq_angle_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] yaw_angle;
  logic signed [W-1:0] pitch_angle;
  logic signed [W-1:0] roll_angle;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface etq_quat_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;
  logic signed [W-1:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

### hw/rtl/etq_cordic_stage.sv
// ---------------------------------------------------------------------------
// etq_cordic_stage
// One registered CORDIC rotation step, applied to all three angle lanes.
// ---------------------------------------------------------------------------
module etq_cordic_stage
  import etq_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  trig_set_t in_set,
  output logic      out_valid,
  output trig_set_t out_set
);

  function automatic trig_lane_t rotate(input trig_lane_t a);
    trig_lane_t r;
    trig_word_t dx;
    trig_word_t dy;
    trig_word_t at;
    r  = a;
    dx = a.y >>> STEP;
    dy = a.x >>> STEP;
    at = atan_q30(5'(STEP));
    if (!a.z[TW-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - at;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + at;
    end
    return r;
  endfunction

  // valid travels with the data; everything holds on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_set.yaw   <= rotate(in_set.yaw);
      out_set.pitch <= rotate(in_set.pitch);
      out_set.roll  <= rotate(in_set.roll);
    end
  end

endmodule

### hw/rtl/etq_prod_stage.sv
// ---------------------------------------------------------------------------
// etq_prod_stage
// Two register stages of Q30 products: the four pair products of roll and
// pitch terms, then each pair times the yaw sine and cosine.
// ---------------------------------------------------------------------------
module etq_prod_stage
  import etq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  trig_set_t in_set,
  output logic      out_valid,
  output prod_set_t out_prod
);

  mul_word_t  sr, cr, sp, cp, sy, cy;
  logic       v1;
  trig_word_t sr_cp, cr_sp, cr_cp, sr_sp;
  mul_word_t  sy1, cy1;

  // apply the quadrant flip to the final CORDIC vectors
  always_comb begin
    sr = MW'(in_set.roll.flip  ? -in_set.roll.y  : in_set.roll.y);
    cr = MW'(in_set.roll.flip  ? -in_set.roll.x  : in_set.roll.x);
    sp = MW'(in_set.pitch.flip ? -in_set.pitch.y : in_set.pitch.y);
    cp = MW'(in_set.pitch.flip ? -in_set.pitch.x : in_set.pitch.x);
    sy = MW'(in_set.yaw.flip   ? -in_set.yaw.y   : in_set.yaw.y);
    cy = MW'(in_set.yaw.flip   ? -in_set.yaw.x   : in_set.yaw.x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // pair products
  always_ff @(posedge clk) begin
    if (en) begin
      sr_cp <= mul_q30(sr, cp);
      cr_sp <= mul_q30(cr, sp);
      cr_cp <= mul_q30(cr, cp);
      sr_sp <= mul_q30(sr, sp);
      sy1   <= sy;
      cy1   <= cy;
    end
  end

  // triple products
  always_ff @(posedge clk) begin
    if (en) begin
      out_prod.x_a <= mul_q30(MW'(sr_cp), cy1);
      out_prod.x_b <= mul_q30(MW'(cr_sp), sy1);
      out_prod.y_a <= mul_q30(MW'(cr_sp), cy1);
      out_prod.y_b <= mul_q30(MW'(sr_cp), sy1);
      out_prod.z_a <= mul_q30(MW'(cr_cp), sy1);
      out_prod.z_b <= mul_q30(MW'(sr_sp), cy1);
      out_prod.w_a <= mul_q30(MW'(cr_cp), cy1);
      out_prod.w_b <= mul_q30(MW'(sr_sp), sy1);
    end
  end

endmodule

### hw/rtl/euler_to_quaternion.sv
// ---------------------------------------------------------------------------
// euler_to_quaternion
// Z-Y-X Euler angles to a unit quaternion, fully pipelined.
// ---------------------------------------------------------------------------
// One angle word per cycle is taken and one quaternion word per cycle is
// given unless the output stalls. The pipeline is one quadrant-fold stage,
// one stage per CORDIC rotation (all three angles side by side), two
// multiply stages and a round/saturate output register. The whole pipeline
// advances whenever the output register is empty or being taken, so ready
// drops only while a finished word waits at the output.
module euler_to_quaternion
  import etq_pkg::*;
#(
  parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
  parameter int QUAT_WIDTH      = QUAT_WIDTH_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input logic clk,
  input logic rst,
  etq_angle_if.sink   angles,
  etq_quat_if.source  quat
);

`include "euler_to_quaternion_macros.svh"

  localparam int HS = 33 - ANGLE_WIDTH;
  localparam int SH = 32 - QUAT_WIDTH;
  localparam int SW = TW + 1;
  localparam logic signed [SW-1:0] RND =
    (SH > 0) ? (SW'(1) <<< ((SH > 0) ? SH - 1 : 0)) : SW'(0);
  localparam logic signed [SW-1:0] LIM = SW'(1) <<< (QUAT_WIDTH - 2);

  logic      advance;
  logic      v0;
  trig_set_t set0;
  logic      vc [TRIG_ITERATIONS+1];
  trig_set_t sc [TRIG_ITERATIONS+1];
  logic      vp;
  prod_set_t prod;
  logic      vo;

  // halve the angle into Q30 and fold into the CORDIC range
  function automatic trig_lane_t fold(input logic signed [ANGLE_WIDTH-1:0] a);
    trig_lane_t r;
    trig_word_t z;
    z      = TW'(a) <<< HS;
    r.x    = INV_GAIN;
    r.y    = '0;
    r.flip = 1'b0;
    r.z    = z;
    if (z > HALF_PI_Q30) begin
      r.z    = z - PI_Q30;
      r.flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      r.z    = z + PI_Q30;
      r.flip = 1'b1;
    end
    return r;
  endfunction

  // round Q30 to the output fraction and clamp to +/-1
  function automatic logic signed [QUAT_WIDTH-1:0] to_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + RND) >>> SH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return QUAT_WIDTH'(r);
  endfunction

  assign advance      = !vo || quat.ready;
  assign angles.ready = advance;

  // fold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (advance) begin
      v0 <= angles.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      set0.yaw   <= fold(angles.yaw_angle);
      set0.pitch <= fold(angles.pitch_angle);
      set0.roll  <= fold(angles.roll_angle);
    end
  end

  // CORDIC chain
  assign vc[0] = v0;
  assign sc[0] = set0;

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cordic
    etq_cordic_stage #(.STEP(i)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (vc[i]),
      .in_set    (sc[i]),
      .out_valid (vc[i+1]),
      .out_set   (sc[i+1])
    );
  end

  etq_prod_stage u_prod (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (vc[TRIG_ITERATIONS]),
    .in_set    (sc[TRIG_ITERATIONS]),
    .out_valid (vp),
    .out_prod  (prod)
  );

  // output register: combine, round, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (advance) begin
      vo <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quat.quat_x <= to_out(SW'(prod.x_a) - SW'(prod.x_b));
      quat.quat_y <= to_out(SW'(prod.y_a) + SW'(prod.y_b));
      quat.quat_z <= to_out(SW'(prod.z_a) - SW'(prod.z_b));
      quat.quat_w <= to_out(SW'(prod.w_a) + SW'(prod.w_b));
    end
  end

  assign quat.valid = vo;

  // checks
  `ETQ_ASSERT_IMPLY(a_w_range, clk, rst, quat.valid, (SW'(quat.quat_w) <= LIM) && (SW'(quat.quat_w) >= -LIM), "quat_w out of range")
  `ETQ_ASSERT_NEXT(a_stall_hold, clk, rst, !advance, $stable(v0) && $stable(vp), "pipeline moved during stall")
  `ETQ_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !quat.valid && !v0, "pipeline not empty after reset")

endmodule
